// ----- src/vts_pkg.sv -----
// shared types and constants of the virtual-runtime task scheduler
// no dependencies; used by vruntime_task_scheduler_top
package vts_pkg;

	localparam int DEF_MAX_TASKS    = 16;
	localparam int DEF_MAX_CPUS     = 4;
	localparam int DEF_RUNTIME_BITS = 32;

	// weight of one tick, normalised to a single runtime unit
	localparam int TASK_WEIGHT = 1024;
	localparam int TICK_STEP   = TASK_WEIGHT / TASK_WEIGHT;

	localparam logic [7:0]  LAT_RESET    = 8'd4;
	localparam logic [2:0]  ONLINE_RESET = 3'd1;
	localparam logic [15:0] PID_RESET    = 16'd1;

	// configuration register indexes
	localparam logic CFG_LATENCY = 1'b0;
	localparam logic CFG_ONLINE  = 1'b1;

	// result status codes
	localparam logic [1:0] RS_OK       = 2'd0;
	localparam logic [1:0] RS_NO_SLOT  = 2'd1;
	localparam logic [1:0] RS_NO_ENTRY = 2'd2;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_TICK   = 2'd1,
		OP_YIELD  = 2'd2,
		OP_EXIT   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_UNUSED   = 2'd0,
		ST_RUNNING  = 2'd1,
		ST_RUNNABLE = 2'd2,
		ST_DEAD     = 2'd3
	} slot_st_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN1,
		S_SCAN2,
		S_SW_PREV,
		S_SW_BEST,
		S_RESP
	} fsm_t;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] cpu_id;
		logic       entry_valid;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  task_slot;
		logic        run_idle;
		logic [15:0] new_pid;
		logic        switched;
		logic        resched;
		logic [31:0] queue_min;
	} out_item_t;

endpackage

// ----- src/vruntime_task_scheduler_top.sv -----
// top level of the virtual-runtime task scheduler: task table memory, per-cpu run state
// depends on vts_pkg
//
// usage
//  - command channel: a transaction is taken at a rising edge with start high and busy low;
//    cmd carries op, cpu_id and entry_valid
//  - result channel: done is high for exactly one cycle with the result on result;
//    the receiver cannot stall, so each result must be taken in that cycle
//  - configuration: cfg_we writes cfg_wdata into register cfg_idx at the clock edge
//    (0 latency_ticks, 1 cpus_online); write only while busy is low
// timing
//  - the task table lives in one synchronous memory and is scanned one entry a cycle
//    through its single read port; that port sets the rate
//  - create and tick: one scan, then done strobes
//  - yield and exit: two scans plus up to two write-backs, then done strobes
//  - create without an entry point: no scan; done strobes after the response state
//  - busy is low in the cycle that done strobes, so a new command can follow at once
// reset
//  - arst_n clears all control and per-cpu state at once: slot 0 runs on cpu 0, other slots unused
//    (entries never written read as their reset value), no clearing pass
module vruntime_task_scheduler_top
	import vts_pkg::*;
#(
	parameter int MAX_TASKS    = DEF_MAX_TASKS,
	parameter int MAX_CPUS     = DEF_MAX_CPUS,
	parameter int RUNTIME_BITS = DEF_RUNTIME_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  cmd,
	output logic      done,
	output out_item_t result,
	input  logic      cfg_we,
	input  logic      cfg_idx,
	input  logic [7:0] cfg_wdata
);

	localparam int TW = $clog2(MAX_TASKS);
	localparam int CW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
	localparam int LW = $clog2(MAX_TASKS + 1);
	localparam int RB = RUNTIME_BITS;
	localparam logic [TW:0] IDLE_MARK = (TW + 1)'(MAX_TASKS);

	typedef struct packed {
		slot_st_t      st;
		logic [CW-1:0] cpu;
		logic [RB-1:0] rt;
		logic [15:0]   pid;
	} entry_t;

	// saturating runtime add of one tick
	function automatic logic [RB-1:0] rt_inc(input logic [RB-1:0] v);
		logic [RB:0] s;
		s = {1'b0, v} + (RB + 1)'(TICK_STEP);
		return s[RB] ? {RB{1'b1}} : s[RB-1:0];
	endfunction

	function automatic entry_t reset_entry(input logic [TW-1:0] idx);
		entry_t e;
		e = '0;
		e.st = (idx == '0) ? ST_RUNNING : ST_UNUSED;
		return e;
	endfunction

	// cpu number folded into range by repeated subtraction
	function automatic logic [CW-1:0] cpu_wrap(input logic [1:0] id);
		logic [1:0] v;
		v = id;
		for (int i = 0; i < 4; i++) begin
			if (int'(v) >= MAX_CPUS) begin
				v = v - 2'(MAX_CPUS);
			end
		end
		return CW'(v);
	endfunction

	// control state
	fsm_t          state_q, state_d;
	op_t           op_q;
	logic [CW-1:0] c_q;
	logic [TW:0]   cur_q;
	logic [TW:0]   scan_cnt_q;
	logic          rvalid_s1;
	logic [TW-1:0] ridx_s1;
	logic [MAX_TASKS-1:0] written_q;
	logic [TW:0]   cpu_current_q [MAX_CPUS];
	logic [LW-1:0] cpu_load_q    [MAX_CPUS];
	logic [RB-1:0] cpu_min_q     [MAX_CPUS];
	logic [RB-1:0] idle_rt_q     [MAX_CPUS];
	logic [MAX_CPUS-1:0] resched_q;
	logic [15:0]   pid_q;
	logic [7:0]    lat_q;
	logic [2:0]    online_q;
	logic          done_q;

	// task table memory and scan payload
	entry_t        mem [MAX_TASKS];
	entry_t        rdata_s1;
	logic          rvld_s1;
	logic          found_q, free_found_q;
	logic [1:0]    cnt_q;
	logic [RB-1:0] min_q;
	logic [TW-1:0] best_q, free_q;
	entry_t        best_ent_q, cur_ent_q;
	logic [1:0]    st_q;
	logic          sw_q;
	out_item_t     result_q;

	// combinational
	logic          rd_en, scan_end, scanning;
	logic          mem_we;
	logic [TW-1:0] mem_waddr;
	entry_t        mem_wdata;
	entry_t        ent_eff;
	logic          ent_runnable, ent_free;
	logic          go_scan1, go_scan2;
	logic [CW-1:0] cmd_cpu;
	logic [CW-1:0] place_cpu;
	logic [3:0]    onl;
	logic [TW:0]   best_sel;
	logic          yld_wr;
	logic [RB-1:0] yield_rt;
	logic [RB-1:0] idle_next, vr, min_new;
	logic          cur_valid;
	logic [TW:0]   cur_now;

	assign cmd_cpu   = cpu_wrap(cmd.cpu_id);
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign result    = result_q;
	assign scanning  = (state_q == S_SCAN1) || (state_q == S_SCAN2);
	assign rd_en     = scanning && (scan_cnt_q < (TW + 1)'(MAX_TASKS));
	assign scan_end  = scanning && (scan_cnt_q == (TW + 1)'(MAX_TASKS)) && !rvalid_s1;
	assign cur_valid = (cur_q < IDLE_MARK);
	assign best_sel  = found_q ? {1'b0, best_q} : IDLE_MARK;
	assign yld_wr    = (op_q == OP_YIELD) && (cnt_q == 2'd2) && cur_valid;
	assign yield_rt  = (cur_ent_q.rt <= min_q) ? rt_inc(min_q) : rt_inc(cur_ent_q.rt);
	assign idle_next = rt_inc(idle_rt_q[c_q]);
	assign vr        = cur_valid ? cur_ent_q.rt : idle_next;
	assign min_new   = found_q ? min_q : '0;
	assign cur_now   = cpu_current_q[c_q];

	assign go_scan1 = (state_q == S_IDLE) && start &&
	                  !((op_t'(cmd.op) == OP_CREATE) && !cmd.entry_valid);
	assign go_scan2 = (state_q == S_SCAN1) && scan_end &&
	                  ((op_q == OP_YIELD) || (op_q == OP_EXIT));

	// entry as seen by the scan, with the tick applied to the running task
	always_comb begin
		ent_eff = rvld_s1 ? rdata_s1 : reset_entry(ridx_s1);
		if (state_q == S_SCAN1 && op_q == OP_TICK && {1'b0, ridx_s1} == cur_q) begin
			ent_eff.rt = rt_inc(ent_eff.rt);
		end
		ent_runnable = (ent_eff.cpu == c_q) &&
		               (ent_eff.st == ST_RUNNING || ent_eff.st == ST_RUNNABLE);
		ent_free     = (ent_eff.st == ST_UNUSED) || (ent_eff.st == ST_DEAD);
	end

	// least-loaded online cpu, ties to the caller then the lowest index
	always_comb begin
		onl = {1'b0, online_q};
		if (onl == 4'd0) begin
			onl = 4'd1;
		end
		if (int'(onl) > MAX_CPUS) begin
			onl = 4'(MAX_CPUS);
		end
		place_cpu = c_q;
		for (int k = 0; k < MAX_CPUS; k++) begin
			if (k < int'(onl) && cpu_load_q[k] < cpu_load_q[place_cpu]) begin
				place_cpu = CW'(k);
			end
		end
	end

	// next state and memory write port
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = cur_q[TW-1:0];
		mem_wdata = cur_ent_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = go_scan1 ? S_SCAN1 : S_RESP;
				end
			end
			S_SCAN1: begin
				if (scan_end) begin
					state_d = go_scan2 ? S_SCAN2 : S_RESP;
					case (op_q)
						OP_CREATE: begin
							mem_we    = free_found_q;
							mem_waddr = free_q;
							mem_wdata.st  = ST_RUNNABLE;
							mem_wdata.cpu = place_cpu;
							mem_wdata.rt  = '0;
							mem_wdata.pid = pid_q;
						end
						OP_TICK: begin
							mem_we = cur_valid;
						end
						OP_YIELD: begin
							mem_we       = yld_wr;
							mem_wdata.rt = yield_rt;
						end
						OP_EXIT: begin
							mem_we       = cur_valid;
							mem_wdata.st = ST_DEAD;
						end
						default: begin
							mem_we = 1'b0;
						end
					endcase
				end
			end
			S_SCAN2: begin
				if (scan_end) begin
					if (best_sel == cur_q) begin
						state_d = S_RESP;
					end else if (cur_valid && cur_ent_q.st == ST_RUNNING) begin
						state_d = S_SW_PREV;
					end else if (found_q) begin
						state_d = S_SW_BEST;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_SW_PREV: begin
				mem_we       = 1'b1;
				mem_wdata.st = ST_RUNNABLE;
				state_d      = found_q ? S_SW_BEST : S_RESP;
			end
			S_SW_BEST: begin
				mem_we       = 1'b1;
				mem_waddr    = best_q;
				mem_wdata    = best_ent_q;
				mem_wdata.st = ST_RUNNING;
				state_d      = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// task table: one read and one write port, read data registered
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_s1 <= mem[scan_cnt_q[TW-1:0]];
			rvld_s1  <= written_q[scan_cnt_q[TW-1:0]];
		end
	end

	// control and per-cpu state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= OP_CREATE;
			c_q        <= '0;
			cur_q      <= '0;
			scan_cnt_q <= '0;
			rvalid_s1  <= 1'b0;
			ridx_s1    <= '0;
			written_q  <= '0;
			resched_q  <= '0;
			pid_q      <= PID_RESET;
			lat_q      <= LAT_RESET;
			online_q   <= ONLINE_RESET;
			done_q     <= 1'b0;
			for (int i = 0; i < MAX_CPUS; i++) begin
				cpu_current_q[i] <= (i == 0) ? '0 : IDLE_MARK;
				cpu_load_q[i]    <= (i == 0) ? LW'(1) : '0;
				cpu_min_q[i]     <= '0;
				idle_rt_q[i]     <= '0;
			end
		end else begin
			done_q    <= (state_q == S_RESP);
			rvalid_s1 <= rd_en;
			if (rd_en) begin
				ridx_s1    <= scan_cnt_q[TW-1:0];
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (go_scan1 || go_scan2) begin
				scan_cnt_q <= '0;
			end
			if (mem_we) begin
				written_q[mem_waddr] <= 1'b1;
			end
			if (cfg_we) begin
				if (cfg_idx == CFG_LATENCY) begin
					lat_q <= cfg_wdata;
				end else begin
					online_q <= cfg_wdata[2:0];
				end
			end
			if (state_q == S_IDLE && start) begin
				op_q  <= op_t'(cmd.op);
				c_q   <= cmd_cpu;
				cur_q <= cpu_current_q[cmd_cpu];
			end
			if (state_q == S_SCAN1 && scan_end) begin
				case (op_q)
					OP_CREATE: begin
						if (free_found_q) begin
							cpu_load_q[place_cpu] <= cpu_load_q[place_cpu] + 1'b1;
							resched_q[place_cpu]  <= 1'b1;
							pid_q                 <= pid_q + 16'd1;
						end
					end
					OP_TICK: begin
						if (!cur_valid) begin
							idle_rt_q[c_q] <= idle_next;
						end
						cpu_min_q[c_q] <= min_new;
						if (cnt_q == 2'd2 && vr >= min_new && (vr - min_new) >= RB'(lat_q)) begin
							resched_q[c_q] <= 1'b1;
						end
					end
					OP_YIELD: begin
						resched_q[c_q] <= 1'b1;
					end
					OP_EXIT: begin
						if (cur_valid && cpu_load_q[c_q] != '0) begin
							cpu_load_q[c_q] <= cpu_load_q[c_q] - 1'b1;
						end
					end
					default: begin
						resched_q[c_q] <= resched_q[c_q];
					end
				endcase
			end
			if (state_q == S_SCAN2 && scan_end) begin
				cpu_min_q[c_q]     <= min_new;
				resched_q[c_q]     <= 1'b0;
				cpu_current_q[c_q] <= best_sel;
			end
		end
	end

	// scan accumulators and result payload
	always_ff @(posedge clk) begin
		if (go_scan1 || go_scan2) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			cnt_q        <= '0;
		end else if (rvalid_s1) begin
			if (ent_runnable) begin
				if (cnt_q != 2'd2) begin
					cnt_q <= cnt_q + 2'd1;
				end
				if (!found_q || ent_eff.rt < min_q) begin
					found_q    <= 1'b1;
					min_q      <= ent_eff.rt;
					best_q     <= ridx_s1;
					best_ent_q <= ent_eff;
				end
			end
			if (ent_free && !free_found_q) begin
				free_found_q <= 1'b1;
				free_q       <= ridx_s1;
			end
			if (state_q == S_SCAN1 && {1'b0, ridx_s1} == cur_q) begin
				cur_ent_q <= ent_eff;
			end
		end
		if (state_q == S_IDLE && start) begin
			st_q <= (op_t'(cmd.op) == OP_CREATE && !cmd.entry_valid) ? RS_NO_ENTRY : RS_OK;
			sw_q <= 1'b0;
		end
		if (state_q == S_SCAN1 && scan_end) begin
			if (op_q == OP_CREATE && !free_found_q) begin
				st_q <= RS_NO_SLOT;
			end
			if (yld_wr) begin
				cur_ent_q.rt <= yield_rt;
			end
			if (op_q == OP_EXIT && cur_valid) begin
				cur_ent_q.st <= ST_DEAD;
			end
		end
		if (state_q == S_SCAN2 && scan_end) begin
			sw_q <= (best_sel != cur_q);
		end
		if (state_q == S_RESP) begin
			result_q.status   <= st_q;
			result_q.run_idle <= (cur_now >= IDLE_MARK);
			result_q.switched <= sw_q;
			result_q.resched  <= resched_q[c_q];
			result_q.queue_min <= 32'(cpu_min_q[c_q]);
			if (op_q == OP_CREATE) begin
				result_q.task_slot <= (st_q == RS_OK) ? 4'(free_q) : 4'd0;
				result_q.new_pid   <= (st_q == RS_OK) ? pid_q - 16'd1 : 16'd0;
			end else begin
				result_q.task_slot <= (cur_now < IDLE_MARK) ? 4'(cur_now) : 4'd0;
				result_q.new_pid   <= 16'd0;
			end
		end
	end

	// checks
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && mem_we))
		else $error("task table read and write in the same cycle");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_cnt_q <= (TW + 1)'(MAX_TASKS))
		else $error("scan counter beyond table");

	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result strobed in the cycle after acceptance");

	a_switch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.switched) |-> (result.status == RS_OK))
		else $error("switch reported with a failing status");

endmodule

// ----- verif/vts_sched_checker.sv -----
// scoreboard of the virtual-runtime task scheduler: watches the command, result and
// configuration ports, predicts each result and compares it field by field
// depends on vts_pkg
module vts_sched_checker
	import vts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  in_item_t  cmd,
	input  logic      done,
	input  out_item_t result,
	input  logic      cfg_we,
	input  logic      cfg_idx,
	input  logic [7:0] cfg_wdata,
	output int        errors,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NT = DEF_MAX_TASKS;
	localparam int NC = DEF_MAX_CPUS;
	localparam int IDLE_SLOT = NT;

	slot_st_t    task_st[NT];
	logic [1:0]  task_cpu[NT];
	logic [31:0] task_vrt[NT];
	logic [15:0] task_pid[NT];
	int          running[NC];
	int          load[NC];
	logic [31:0] min_vrt[NC];
	bit          resched_req[NC];
	logic [31:0] idle_vrt[NC];
	logic [15:0] pid_next;
	logic [7:0]  lat_cfg;
	logic [2:0]  online_cfg;

	out_item_t expected_results[$];

	assign pending = expected_results.size();

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic bit on_queue(int t, int c);
		return task_cpu[t] == c && (task_st[t] == ST_RUNNING || task_st[t] == ST_RUNNABLE);
	endfunction

	function automatic int queue_len(int c);
		int n = 0;
		for (int t = 0; t < NT; t++) if (on_queue(t, c)) n++;
		return n;
	endfunction

	function automatic void refresh_min(int c);
		bit found = 0;
		logic [31:0] m = '0;
		for (int t = 0; t < NT; t++) begin
			if (on_queue(t, c) && (!found || task_vrt[t] < m)) begin
				m = task_vrt[t];
				found = 1;
			end
		end
		min_vrt[c] = m;
	endfunction

	// pick the smallest runtime on the queue, lowest slot on ties, else idle
	function automatic bit pick_next(int c);
		int best = IDLE_SLOT;
		int prev = running[c];
		for (int t = 0; t < NT; t++) begin
			if (on_queue(t, c) && (best == IDLE_SLOT || task_vrt[t] < task_vrt[best]))
				best = t;
		end
		refresh_min(c);
		resched_req[c] = 0;
		if (best == prev) return 0;
		if (prev < NT && task_st[prev] == ST_RUNNING) task_st[prev] = ST_RUNNABLE;
		if (best < NT) task_st[best] = ST_RUNNING;
		running[c] = best;
		return 1;
	endfunction

	function automatic out_item_t sched_next(in_item_t it);
		out_item_t r = '0;
		int c = it.cpu_id;
		int cur = running[c];
		int t, online, best;
		logic [31:0] vr;
		case (op_t'(it.op))
			OP_CREATE: begin
				if (!it.entry_valid) begin
					r.status = RS_NO_ENTRY;
				end else begin
					for (t = 0; t < NT; t++)
						if (task_st[t] == ST_UNUSED || task_st[t] == ST_DEAD) break;
					if (t == NT) begin
						r.status = RS_NO_SLOT;
					end else begin
						online = (online_cfg < 1) ? 1 : (online_cfg > NC) ? NC : online_cfg;
						best = c;
						for (int k = 0; k < online; k++) if (load[k] < load[best]) best = k;
						task_pid[t] = pid_next;
						pid_next = pid_next + 16'd1;
						task_vrt[t] = '0;
						task_cpu[t] = best[1:0];
						task_st[t] = ST_RUNNABLE;
						load[best]++;
						resched_req[best] = 1;
						r.task_slot = t[3:0];
						r.new_pid = task_pid[t];
					end
				end
			end
			OP_TICK: begin
				if (cur < NT) begin
					task_vrt[cur] = sat_inc(task_vrt[cur]);
					vr = task_vrt[cur];
				end else begin
					idle_vrt[c] = sat_inc(idle_vrt[c]);
					vr = idle_vrt[c];
				end
				refresh_min(c);
				if (queue_len(c) > 1 && vr >= min_vrt[c] && vr - min_vrt[c] >= lat_cfg)
					resched_req[c] = 1;
			end
			OP_YIELD: begin
				if (queue_len(c) > 1 && cur < NT) begin
					refresh_min(c);
					if (task_vrt[cur] <= min_vrt[c]) task_vrt[cur] = sat_inc(min_vrt[c]);
					else task_vrt[cur] = sat_inc(task_vrt[cur]);
				end
				resched_req[c] = 1;
				r.switched = pick_next(c);
			end
			default: begin
				if (cur < NT) begin
					task_st[cur] = ST_DEAD;
					if (load[c] > 0) load[c]--;
				end
				r.switched = pick_next(c);
			end
		endcase
		if (op_t'(it.op) != OP_CREATE && running[c] < NT) r.task_slot = running[c][3:0];
		r.run_idle = running[c] >= NT;
		r.resched = resched_req[c];
		r.queue_min = min_vrt[c];
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic compare(out_item_t got, out_item_t want);
		if (got.status    !== want.status)    report("status", got.status, want.status);
		if (got.task_slot !== want.task_slot) report("task_slot", got.task_slot, want.task_slot);
		if (got.run_idle  !== want.run_idle)  report("run_idle", got.run_idle, want.run_idle);
		if (got.new_pid   !== want.new_pid)   report("new_pid", got.new_pid, want.new_pid);
		if (got.switched  !== want.switched)  report("switched", got.switched, want.switched);
		if (got.resched   !== want.resched)   report("resched", got.resched, want.resched);
		if (got.queue_min !== want.queue_min) report("queue_min", got.queue_min, want.queue_min);
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NT; t++) begin
				task_st[t] = ST_UNUSED;
				task_cpu[t] = '0;
				task_vrt[t] = '0;
				task_pid[t] = '0;
			end
			for (int c = 0; c < NC; c++) begin
				running[c] = IDLE_SLOT;
				load[c] = 0;
				min_vrt[c] = '0;
				resched_req[c] = 0;
				idle_vrt[c] = '0;
			end
			task_st[0] = ST_RUNNING;
			running[0] = 0;
			load[0] = 1;
			pid_next = PID_RESET;
			lat_cfg = LAT_RESET;
			online_cfg = ONLINE_RESET;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("%0t result with nothing expected", $realtime);
					errors++;
				end else begin
					compare(result, expected_results.pop_front());
				end
			end
			if (cfg_we) begin
				if (cfg_idx == CFG_LATENCY) lat_cfg = cfg_wdata;
				else online_cfg = cfg_wdata[2:0];
			end
			if (start && !busy) expected_results.push_back(sched_next(cmd));
		end
	end

endmodule

// ----- verif/vruntime_task_scheduler_top_tb.sv -----
// testbench top of the virtual-runtime task scheduler: clock, reset, command stimulus
// and configuration; depends on vts_pkg, vruntime_task_scheduler_top and vts_sched_checker
module vruntime_task_scheduler_top_tb;
	import vts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	in_item_t  cmd = '0;
	logic      done;
	out_item_t result;
	logic      cfg_we = 1'b0;
	logic      cfg_idx = CFG_LATENCY;
	logic [7:0] cfg_wdata = '0;
	int        errors;
	int        pending;
	int        gap_pct;

	always #5 clk = ~clk;

	vruntime_task_scheduler_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	vts_sched_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .errors(errors), .pending(pending)
	);

	// one command transaction; start stays high across back-to-back commands so it
	// only ever gets one assignment per time step
	task automatic issue(op_t op, logic [1:0] cpu, logic entry);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		start <= 1'b1;
		cmd <= '{op: op, cpu_id: cpu, entry_valid: entry};
		// busy read here is its value before this edge, so low means taken
		do @(posedge clk); while (busy);
	endtask

	// let every outstanding transaction come back before touching a register
	task automatic drain;
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			// creates mostly carry an entry point; exits keep the table from filling up
			if (pick < 28)      issue(OP_CREATE, 2'($urandom), $urandom_range(9) != 0);
			else if (pick < 65) issue(OP_TICK, 2'($urandom), 1'($urandom));
			else if (pick < 85) issue(OP_YIELD, 2'($urandom), 1'($urandom));
			else                issue(OP_EXIT, 2'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		gap_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset configuration, idle cpus, missing entry point
		issue(OP_TICK, 2'd0, 1'b0);
		issue(OP_CREATE, 2'd3, 1'b0);
		issue(OP_TICK, 2'd1, 1'b1);
		issue(OP_YIELD, 2'd2, 1'b0);
		issue(OP_EXIT, 2'd3, 1'b1);
		drain();
		// out-of-range cpu count clamps to all cpus; smallest nonzero latency
		write_reg(CFG_ONLINE, 8'd7);
		write_reg(CFG_LATENCY, 8'd1);
		// fill the table, then one more create finds no free slot
		repeat (16) issue(OP_CREATE, 2'd2, 1'b1);
		issue(OP_TICK, 2'd0, 1'b0);
		issue(OP_TICK, 2'd0, 1'b0);
		issue(OP_YIELD, 2'd0, 1'b1);
		issue(OP_EXIT, 2'd1, 1'b0);
		drain();
		// zero cpus online clamps to one
		write_reg(CFG_ONLINE, 8'd0);
		write_reg(CFG_LATENCY, 8'd255);
		issue(OP_CREATE, 2'd3, 1'b1);
		issue(OP_EXIT, 2'd2, 1'b0);
		drain();

		// sender idles, then not at all; settings change between phases
		write_reg(CFG_ONLINE, 8'd4);
		write_reg(CFG_LATENCY, 8'd1);
		gap_pct = 10;
		random_phase(280);
		drain();
		write_reg(CFG_ONLINE, 8'd2);
		write_reg(CFG_LATENCY, 8'd255);
		gap_pct = 84;
		random_phase(270);
		drain();
		write_reg(CFG_ONLINE, 8'd3);
		write_reg(CFG_LATENCY, 8'($urandom_range(2, 8)));
		random_phase(270);
		drain();
		write_reg(CFG_ONLINE, 8'd1);
		write_reg(CFG_LATENCY, 8'($urandom_range(1, 6)));
		gap_pct = 0;
		random_phase(280);
		drain();
		write_reg(CFG_ONLINE, 8'd4);
		write_reg(CFG_LATENCY, 8'($urandom_range(1, 255)));
		random_phase(530);
		drain();

		// yield and exit take the longest, so allow a margin beyond them
		repeat (60) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// generous guard against a hung handshake
	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
